### design/serial_frame_receiver_crc8_assert.svh
`ifndef SERIAL_FRAME_RECEIVER_CRC8_ASSERT_SVH
`define SERIAL_FRAME_RECEIVER_CRC8_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfr assertion failed");

// Next-cycle implication, checked out of reset.
`define SFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfr assertion failed");

`endif

### design/sfr_pkg.sv
package sfr_pkg;

    localparam int MAX_PAYLOAD = 32;
    localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int IDX_W       = $clog2(MAX_PAYLOAD);
    localparam int POS_W       = 6;

    localparam logic [7:0]       CRC_POLY     = 8'h07;
    localparam logic [7:0]       NIBBLE_MASK  = 8'h0F;
    localparam logic [POS_W-1:0] HDR_OVERHEAD = POS_W'(4);
    localparam logic [POS_W-1:0] PAYLOAD_OFS  = POS_W'(3);

    localparam logic [1:0] REG_START_BYTE  = 2'd0;
    localparam logic [1:0] REG_OWN_ADDRESS = 2'd1;
    localparam logic [1:0] REG_TIMEOUT_MS  = 2'd2;

    localparam logic [7:0] RST_START_BYTE  = 8'hA5;
    localparam logic [3:0] RST_OWN_ADDRESS = 4'h1;
    localparam logic [7:0] RST_TIMEOUT_MS  = 8'd10;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [3:0] own_address;
        logic [7:0] timeout_ms;
    } t_cfg;

    typedef struct packed {
        logic take;
        logic rd_start;
        logic rd_next;
        logic load_out;
        logic load_empty;
    } t_cmd;

    typedef struct packed {
        logic emit;
        logic empty;
        logic out_last;
    } t_status;

    function automatic logic [7:0] crc8_add(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

### design/sfr_ram.sv
module sfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/sfr_ctrl.sv
`include "serial_frame_receiver_crc8_assert.svh"

module sfr_ctrl
    import sfr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_stall,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_in_stall,
    output logic    o_out_valid
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       out_beat;

    assign out_beat = (r_state == S_OUT) && !i_out_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.take = i_in_valid;
                if (i_in_valid && i_status.emit) begin
                    if (i_status.empty) begin
                        o_cmd.load_empty = 1'b1;
                        n_state          = S_OUT;
                    end else begin
                        o_cmd.rd_start = 1'b1;
                        n_state        = S_RD;
                    end
                end
            end
            S_RD: begin
                o_cmd.load_out = 1'b1;
                o_cmd.rd_next  = 1'b1;
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (out_beat) begin
                    if (i_status.out_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.load_out = 1'b1;
                        o_cmd.rd_next  = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    `SFR_ASSERT_NEXT(a_emit_leaves_idle, i_clk, i_rst_n,
        (r_state == S_IDLE) && i_in_valid && i_status.emit, r_state != S_IDLE)
    `SFR_ASSERT_NEXT(a_read_then_out, i_clk, i_rst_n, r_state == S_RD, r_state == S_OUT)
    `SFR_ASSERT_NEXT(a_last_beat_ends, i_clk, i_rst_n,
        out_beat && i_status.out_last, r_state == S_IDLE)

endmodule

### design/sfr_dp.sv
module sfr_dp
    import sfr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  t_cmd             i_cmd,
    input  logic             i_mode,
    input  logic [7:0]       i_rx_byte,
    output t_status          o_status,
    output logic [3:0]       o_command,
    output logic [LEN_W-1:0] o_data_len,
    output logic [IDX_W-1:0] o_byte_index,
    output logic [7:0]       o_payload_byte,
    output logic             o_has_byte,
    output logic             o_last
);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] r_exp, n_exp;
    logic [7:0]       r_crc, n_crc;
    logic [7:0]       r_hdr, n_hdr;
    logic [LEN_W-1:0] r_len, n_len;
    logic [7:0]       r_idle, n_idle;

    logic [IDX_W-1:0] r_rd_addr;
    logic [IDX_W-1:0] r_load_idx;

    logic [3:0]       r_out_cmd;
    logic [LEN_W-1:0] r_out_len;
    logic [IDX_W-1:0] r_out_idx;
    logic [7:0]       r_out_byte;
    logic             r_out_has;
    logic             r_out_last;

    logic             is_start;
    logic             too_long;
    logic             crc_pos;
    logic [7:0]       idle_inc;
    logic [POS_W-1:0] wr_ofs;
    logic             wr_en;
    logic [IDX_W-1:0] rd_addr;
    logic             rd_en;
    logic [7:0]       ram_q;

    assign is_start = (i_rx_byte == i_cfg.start_byte);
    assign too_long = (i_rx_byte > 8'(MAX_PAYLOAD));
    assign crc_pos  = (r_exp != '0) && (r_pos + POS_W'(1) == r_exp);
    assign idle_inc = (r_idle == 8'hFF) ? r_idle : r_idle + 8'd1;
    assign wr_ofs   = r_pos - PAYLOAD_OFS;

    // Frame end with good CRC and own address; restart takes precedence at positions 1 and 2.
    assign o_status.emit = !i_mode && (r_pos != '0) && !((r_pos < PAYLOAD_OFS) && is_start)
                           && crc_pos && (i_rx_byte == r_crc)
                           && (r_hdr[7:4] == i_cfg.own_address);
    assign o_status.empty    = (r_len == '0);
    assign o_status.out_last = r_out_last;

    always_comb begin
        n_pos  = r_pos;
        n_exp  = r_exp;
        n_crc  = r_crc;
        n_hdr  = r_hdr;
        n_len  = r_len;
        n_idle = r_idle;
        wr_en  = 1'b0;
        if (i_cmd.take) begin
            if (i_mode) begin
                n_idle = idle_inc;
                if ((r_pos != '0) && (idle_inc > i_cfg.timeout_ms)) begin
                    n_pos = '0;
                    n_exp = '0;
                end
            end else begin
                n_idle = '0;
                priority if (r_pos == '0) begin
                    if (is_start) begin
                        n_pos = POS_W'(1);
                        n_exp = '0;
                        n_crc = crc8_add(8'h00, i_rx_byte);
                    end
                end else if ((r_pos < PAYLOAD_OFS) && is_start) begin
                    n_pos = POS_W'(1);
                    n_exp = '0;
                    n_crc = crc8_add(8'h00, i_rx_byte);
                end else if (crc_pos) begin
                    n_pos = '0;
                    n_exp = '0;
                end else if ((r_pos == POS_W'(2)) && too_long) begin
                    n_pos = '0;
                    n_exp = '0;
                end else begin
                    if (r_pos == POS_W'(1)) begin
                        n_hdr = i_rx_byte;
                    end else if (r_pos == POS_W'(2)) begin
                        n_len = i_rx_byte[LEN_W-1:0];
                        n_exp = POS_W'(i_rx_byte[LEN_W-1:0]) + HDR_OVERHEAD;
                    end else begin
                        wr_en = 1'b1;
                    end
                    n_crc = crc8_add(r_crc, i_rx_byte);
                    n_pos = r_pos + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_exp  <= '0;
            r_crc  <= '0;
            r_hdr  <= '0;
            r_len  <= '0;
            r_idle <= '0;
        end else begin
            r_pos  <= n_pos;
            r_exp  <= n_exp;
            r_crc  <= n_crc;
            r_hdr  <= n_hdr;
            r_len  <= n_len;
            r_idle <= n_idle;
        end
    end

    assign rd_en   = i_cmd.rd_start || i_cmd.rd_next;
    assign rd_addr = i_cmd.rd_start ? '0 : r_rd_addr;

    sfr_ram #(
        .WIDTH(8),
        .DEPTH(MAX_PAYLOAD)
    ) u_payload_ram (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(wr_ofs[IDX_W-1:0]),
        .i_wdata(i_rx_byte),
        .i_re   (rd_en),
        .i_raddr(rd_addr),
        .o_rdata(ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_addr <= rd_addr + IDX_W'(1);
        end
        if (i_cmd.rd_start) begin
            r_load_idx <= '0;
        end else if (i_cmd.load_out) begin
            r_load_idx <= r_load_idx + IDX_W'(1);
        end
        if (i_cmd.load_empty) begin
            r_out_cmd  <= r_hdr[3:0] & NIBBLE_MASK[3:0];
            r_out_len  <= '0;
            r_out_idx  <= '0;
            r_out_byte <= '0;
            r_out_has  <= 1'b0;
            r_out_last <= 1'b1;
        end else if (i_cmd.load_out) begin
            r_out_cmd  <= r_hdr[3:0] & NIBBLE_MASK[3:0];
            r_out_len  <= r_len;
            r_out_idx  <= r_load_idx;
            r_out_byte <= ram_q;
            r_out_has  <= 1'b1;
            r_out_last <= (LEN_W'(r_load_idx) + LEN_W'(1) == r_len);
        end
    end

    assign o_command      = r_out_cmd;
    assign o_data_len     = r_out_len;
    assign o_byte_index   = r_out_idx;
    assign o_payload_byte = r_out_byte;
    assign o_has_byte     = r_out_has;
    assign o_last         = r_out_last;

endmodule

### design/serial_frame_receiver_crc8.sv
// Channel  Direction  Handshake               Payload
// input    in         i_in_valid / o_in_stall  i_mode, i_rx_byte
// result   out        o_out_valid / i_out_stall o_command .. o_last
// config   in         APB psel/penable/pwrite  paddr, pwdata, prdata
//
// A byte or tick that ends no good frame is taken without stalling the input.
// A good frame stalls the input until its last result beat is taken,
// with a payload read state (S_RD) in front when the payload is not empty.
// The payload RAM read port sets one result beat per cycle when not stalled.
// Reset is synchronous and needs no clearing pass; output stalls hold the beat.
module serial_frame_receiver_crc8
    import sfr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [3:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_mode,
    input  logic [7:0]       i_rx_byte,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [3:0]       o_command,
    output logic [LEN_W-1:0] o_data_len,
    output logic [IDX_W-1:0] o_byte_index,
    output logic [7:0]       o_payload_byte,
    output logic             o_has_byte,
    output logic             o_last
);

    t_cfg       r_cfg;
    t_cmd       cmd;
    t_status    status;
    logic       cfg_wr;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte  <= RST_START_BYTE;
            r_cfg.own_address <= RST_OWN_ADDRESS;
            r_cfg.timeout_ms  <= RST_TIMEOUT_MS;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_START_BYTE:  r_cfg.start_byte  <= pwdata[7:0];
                REG_OWN_ADDRESS: r_cfg.own_address <= pwdata[3:0];
                REG_TIMEOUT_MS:  r_cfg.timeout_ms  <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_START_BYTE:  prdata = 32'(r_cfg.start_byte);
            REG_OWN_ADDRESS: prdata = 32'(r_cfg.own_address);
            REG_TIMEOUT_MS:  prdata = 32'(r_cfg.timeout_ms);
            default:         prdata = '0;
        endcase
    end

    sfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_stall(i_out_stall),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid)
    );

    sfr_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_cmd         (cmd),
        .i_mode        (i_mode),
        .i_rx_byte     (i_rx_byte),
        .o_status      (status),
        .o_command     (o_command),
        .o_data_len    (o_data_len),
        .o_byte_index  (o_byte_index),
        .o_payload_byte(o_payload_byte),
        .o_has_byte    (o_has_byte),
        .o_last        (o_last)
    );

endmodule

### verif/serial_frame_receiver_crc8_tb.sv
`timescale 1ns / 100ps

module serial_frame_receiver_crc8_tb;
    import sfr_pkg::*;

    localparam int RUN_LIMIT = 500000;

    typedef struct packed {
        logic [3:0]       command;
        logic [LEN_W-1:0] data_len;
        logic [IDX_W-1:0] byte_index;
        logic [7:0]       payload_byte;
        logic             has_byte;
        logic             last;
    } t_delivered;

    logic             i_clk;
    logic             i_rst_n;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [3:0]       paddr;
    logic [31:0]      pwdata;
    logic [31:0]      prdata;
    logic             pready;
    logic             i_in_valid;
    logic             o_in_stall;
    logic             i_mode;
    logic [7:0]       i_rx_byte;
    logic             o_out_valid;
    logic             i_out_stall;
    logic [3:0]       o_command;
    logic [LEN_W-1:0] o_data_len;
    logic [IDX_W-1:0] o_byte_index;
    logic [7:0]       o_payload_byte;
    logic             o_has_byte;
    logic             o_last;

    logic [7:0] cfg_start   = RST_START_BYTE;
    logic [3:0] cfg_addr    = RST_OWN_ADDRESS;
    logic [7:0] cfg_timeout = RST_TIMEOUT_MS;

    logic [5:0] frm_pos     = '0;
    logic [5:0] frm_total   = '0;
    logic [7:0] frm_crc     = '0;
    logic [7:0] frm_header  = '0;
    logic [5:0] frm_len     = '0;
    logic [7:0] frm_payload [MAX_PAYLOAD];
    logic [7:0] idle_count  = '0;

    t_delivered deliveries_due[$];
    t_delivered due_now;
    int         mismatches = 0;
    int         beats_sent = 0;
    int         cycles     = 0;
    bit         quiet      = 1'b0;

    serial_frame_receiver_crc8 DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_command      (o_command),
        .o_data_len     (o_data_len),
        .o_byte_index   (o_byte_index),
        .o_payload_byte (o_payload_byte),
        .o_has_byte     (o_has_byte),
        .o_last         (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] data);
        logic [7:0] r;
        r = acc ^ data;
        repeat (8) r = (r << 1) ^ (r[7] ? CRC_POLY : 8'h00);
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("mismatch in %s: got %0d, expected %0d (cycle %0d)", what, got, want, cycles);
    endtask

    task automatic track_rx_beat(input logic mode, input logic [7:0] b);
        t_delivered d;
        logic [5:0] pos;
        int         n;
        if (mode) begin
            if (idle_count != 8'hFF)
                idle_count = idle_count + 8'd1;
            if (frm_pos != 0 && idle_count > cfg_timeout) begin
                frm_pos   = '0;
                frm_total = '0;
            end
        end else begin
            idle_count = '0;
            pos = frm_pos;
            if (pos == 0 || (pos < 3 && b == cfg_start)) begin
                if (b == cfg_start) begin
                    frm_pos   = 6'd1;
                    frm_total = '0;
                    frm_crc   = crc8_next(8'h00, b);
                end
            end else if (frm_total != 0 && pos + 6'd1 == frm_total) begin
                frm_pos   = '0;
                frm_total = '0;
                if (b == frm_crc && frm_header[7:4] == cfg_addr) begin
                    n = frm_len;
                    d.command = frm_header[3:0];
                    if (n == 0) begin
                        d.data_len     = '0;
                        d.byte_index   = '0;
                        d.payload_byte = '0;
                        d.has_byte     = 1'b0;
                        d.last         = 1'b1;
                        deliveries_due.push_back(d);
                    end else begin
                        for (int i = 0; i < n; i++) begin
                            d.data_len     = LEN_W'(n);
                            d.byte_index   = IDX_W'(i);
                            d.payload_byte = frm_payload[i];
                            d.has_byte     = 1'b1;
                            d.last         = (i + 1 == n);
                            deliveries_due.push_back(d);
                        end
                    end
                end
            end else if (pos == 2 && b > MAX_PAYLOAD) begin
                frm_pos   = '0;
                frm_total = '0;
            end else begin
                if (pos == 1)
                    frm_header = b;
                else if (pos == 2) begin
                    frm_len   = 6'(b);
                    frm_total = 6'(b + 4);
                end else
                    frm_payload[int'(pos) - 3] = b;
                frm_crc = crc8_next(frm_crc, b);
                frm_pos = pos + 6'd1;
            end
        end
    endtask

    task automatic push_rx_beat(input logic mode, input logic [7:0] b);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_rx_byte  <= b;
        track_rx_beat(mode, b);
        beats_sent++;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_ticks(input int count);
        repeat (count) push_rx_beat(1'b1, 8'($urandom));
    endtask

    // A pause of zero or more sends that many ticks after the header; a negative pause
    // scatters short tick bursts through the frame.
    task automatic drive_frame(input logic [7:0] hdr, input logic [7:0] len_byte, input int fill,
                               input bit bad_crc, input int cut, input int pause);
        logic [7:0] seq[$];
        logic [7:0] crc;
        seq.push_back(cfg_start);
        seq.push_back(hdr);
        seq.push_back(len_byte);
        if (len_byte <= MAX_PAYLOAD) begin
            for (int k = 0; k < len_byte; k++)
                seq.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
            crc = 8'h00;
            foreach (seq[k]) crc = crc8_next(crc, seq[k]);
            seq.push_back(bad_crc ? crc ^ 8'($urandom_range(1, 255)) : crc);
        end
        if (cut > 0)
            while (seq.size() > cut) void'(seq.pop_back());
        foreach (seq[k]) begin
            push_rx_beat(1'b0, seq[k]);
            if (k == 1 && pause > 0)
                send_ticks(pause);
            else if (pause < 0 && $urandom_range(0, 19) == 0)
                send_ticks($urandom_range(1, (cfg_timeout < 16) ? int'(cfg_timeout) + 2 : 16));
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (deliveries_due.size() != 0);
    endtask

    task automatic settle(input int tail);
        wait_drained();
        repeat (tail) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'h0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_START_BYTE:  cfg_start   = val;
            REG_OWN_ADDRESS: cfg_addr    = val[3:0];
            REG_TIMEOUT_MS:  cfg_timeout = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic test_special_frames();
        logic [7:0] crc;
        push_rx_beat(1'b0, 8'h00);
        push_rx_beat(1'b0, 8'hFF);
        push_rx_beat(1'b1, cfg_start);
        drive_frame({cfg_addr, 4'hC}, 8'd0, -1, 1'b0, -1, 0);
        push_rx_beat(1'b0, cfg_start);
        push_rx_beat(1'b0, cfg_start);
        push_rx_beat(1'b0, {cfg_addr, 4'hF});
        push_rx_beat(1'b0, cfg_start);
        push_rx_beat(1'b0, {cfg_addr, 4'hF});
        push_rx_beat(1'b0, 8'h01);
        push_rx_beat(1'b0, 8'hFF);
        crc = crc8_next(crc8_next(crc8_next(crc8_next(8'h00, cfg_start),
                                            {cfg_addr, 4'hF}), 8'h01), 8'hFF);
        push_rx_beat(1'b0, crc);
        drive_frame({cfg_addr, 4'h1}, 8'(MAX_PAYLOAD + 1), -1, 1'b0, -1, 0);
        drive_frame({cfg_addr, 4'h0}, 8'd1, 8'h00, 1'b1, -1, 0);
        drive_frame({cfg_addr + 4'd1, 4'hF}, 8'd0, -1, 1'b0, -1, 0);
        settle(4);
    endtask

    task automatic test_idle_timeout();
        write_reg(REG_TIMEOUT_MS, 8'd0);
        push_rx_beat(1'b0, cfg_start);
        push_rx_beat(1'b1, 8'h00);
        push_rx_beat(1'b0, {cfg_addr, 4'h2});
        drive_frame({cfg_addr, 4'h3}, 8'd1, -1, 1'b0, -1, 0);
        settle(4);
        write_reg(REG_TIMEOUT_MS, RST_TIMEOUT_MS);
        drive_frame({cfg_addr, 4'h4}, 8'd0, -1, 1'b0, -1, int'(RST_TIMEOUT_MS));
        drive_frame({cfg_addr, 4'h5}, 8'd0, -1, 1'b0, 2, int'(RST_TIMEOUT_MS) + 1);
        drive_frame({cfg_addr, 4'h6}, 8'd1, -1, 1'b0, -1, 0);
        settle(4);
        write_reg(REG_TIMEOUT_MS, 8'd255);
        quiet = 1'b1;
        drive_frame({cfg_addr, 4'h7}, 8'd2, -1, 1'b0, -1, 20);
        quiet = 1'b0;
        settle(4);
    endtask

    task automatic run_config_phase(input logic [7:0] start, input logic [3:0] addr,
                                    input logic [7:0] tmo, input bit send_full, input int fill);
        int         stop_at;
        int         pick;
        int         len;
        logic [3:0] adr;
        settle(4);
        write_reg(REG_START_BYTE, start);
        write_reg(REG_OWN_ADDRESS, {4'h0, addr});
        write_reg(REG_TIMEOUT_MS, tmo);
        stop_at = beats_sent + 14;
        if (send_full)
            drive_frame({cfg_addr, 4'($urandom)}, 8'(MAX_PAYLOAD), fill, 1'b0, -1, 0);
        while (beats_sent < stop_at) begin
            quiet = ($urandom_range(0, 5) == 0);
            pick  = $urandom_range(0, 99);
            adr   = ($urandom_range(0, 7) == 0) ? 4'($urandom) : cfg_addr;
            len   = ($urandom_range(0, 24) == 0) ? MAX_PAYLOAD : $urandom_range(0, 5);
            if (pick < 70)
                drive_frame({adr, 4'($urandom)}, 8'(len), -1, $urandom_range(0, 9) == 0, -1, -1);
            else if (pick < 78)
                drive_frame({adr, 4'($urandom)}, 8'($urandom_range(MAX_PAYLOAD + 1, 255)),
                            -1, 1'b0, -1, -1);
            else if (pick < 88)
                drive_frame({adr, 4'($urandom)}, 8'(len), -1, 1'b0, $urandom_range(1, 3), -1);
            else if (pick < 95)
                repeat ($urandom_range(1, 3)) push_rx_beat(1'b0, 8'($urandom));
            else
                send_ticks($urandom_range(1, 4));
            if ($urandom_range(0, 24) == 0)
                wait_drained();
        end
        quiet = 1'b0;
    endtask

    task automatic test_config_sweep();
        run_config_phase(8'h00, 4'h0, 8'd0, 1'b1, 8'h00);
        run_config_phase(8'hFF, 4'hF, 8'd255, 1'b1, 8'hFF);
        run_config_phase(8'($urandom), 4'($urandom), 8'($urandom_range(0, 20)), 1'b0, -1);
        run_config_phase(8'($urandom), 4'($urandom), 8'($urandom_range(0, 6)), 1'b0, -1);
        run_config_phase(RST_START_BYTE, RST_OWN_ADDRESS, RST_TIMEOUT_MS, 1'b0, -1);
    endtask

    initial begin
        int hold;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) begin
                hold = quiet ? 0 : $urandom_range(0, 17);
                if (hold > 0) begin
                    i_out_stall <= 1'b1;
                    repeat (hold) @(posedge i_clk);
                    i_out_stall <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (deliveries_due.size() == 0) begin
                flag_mismatch("unexpected result beat, byte_index", o_byte_index, 0);
            end else begin
                due_now = deliveries_due.pop_front();
                if (o_command !== due_now.command)
                    flag_mismatch("command", o_command, due_now.command);
                if (o_data_len !== due_now.data_len)
                    flag_mismatch("data_len", o_data_len, due_now.data_len);
                if (o_byte_index !== due_now.byte_index)
                    flag_mismatch("byte_index", o_byte_index, due_now.byte_index);
                if (due_now.has_byte && o_payload_byte !== due_now.payload_byte)
                    flag_mismatch("payload_byte", o_payload_byte, due_now.payload_byte);
                if (o_has_byte !== due_now.has_byte)
                    flag_mismatch("has_byte", o_has_byte, due_now.has_byte);
                if (o_last !== due_now.last)
                    flag_mismatch("last", o_last, due_now.last);
            end
        end
    end

    initial begin
        i_rst_n    <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        i_in_valid <= 1'b0;
        i_mode     <= 1'b0;
        i_rx_byte  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_special_frames();
        test_idle_timeout();
        test_config_sweep();
        settle(40);
        if (mismatches == 0 && deliveries_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
